// ----- rtl/core/g711_companding_codec_core_macros.svh -----
// ----------------------------------------------------------------------------
// G.711 codec assertion macros
// Shared concurrent assertion forms for the codec core.
// ----------------------------------------------------------------------------
`ifndef G711_COMPANDING_CODEC_CORE_MACROS_SVH
`define G711_COMPANDING_CODEC_CORE_MACROS_SVH

// same-cycle implication
`define G711_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define G711_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/g711_pkg.sv -----
// ----------------------------------------------------------------------------
// G.711 codec package
// Opcodes, segment ends, transcode tables and shared types.
// ----------------------------------------------------------------------------
package g711_pkg;

	typedef logic [2:0]  op_t;
	typedef logic [13:0] mag_t;

	localparam op_t OP_ENC_A = 3'd0;
	localparam op_t OP_ENC_U = 3'd1;
	localparam op_t OP_DEC_A = 3'd2;
	localparam op_t OP_DEC_U = 3'd3;
	localparam op_t OP_A2U   = 3'd4;
	localparam op_t OP_U2A   = 3'd5;

	localparam logic [7:0] A_MSK_POS = 8'hD5;
	localparam logic [7:0] A_MSK_NEG = 8'h55;
	localparam logic [7:0] U_MSK_POS = 8'hFF;
	localparam logic [7:0] U_MSK_NEG = 8'h7F;
	localparam logic [7:0] CODE_MAX  = 8'h7F;
	localparam mag_t       U_CLIP    = 14'd8159;
	localparam mag_t       U_BIAS    = 14'd33;

	localparam mag_t A_SEG_END [8] = '{
		14'h001F, 14'h003F, 14'h007F, 14'h00FF,
		14'h01FF, 14'h03FF, 14'h07FF, 14'h0FFF
	};

	localparam mag_t U_SEG_END [8] = '{
		14'h003F, 14'h007F, 14'h00FF, 14'h01FF,
		14'h03FF, 14'h07FF, 14'h0FFF, 14'h1FFF
	};

	localparam logic [7:0] TAB_U2A [128] = '{
		8'd1, 8'd1, 8'd2, 8'd2, 8'd3, 8'd3, 8'd4, 8'd4,
		8'd5, 8'd5, 8'd6, 8'd6, 8'd7, 8'd7, 8'd8, 8'd8,
		8'd9, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16,
		8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24,
		8'd25, 8'd27, 8'd29, 8'd31, 8'd33, 8'd34, 8'd35, 8'd36,
		8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43, 8'd44,
		8'd46, 8'd48, 8'd49, 8'd50, 8'd51, 8'd52, 8'd53, 8'd54,
		8'd55, 8'd56, 8'd57, 8'd58, 8'd59, 8'd60, 8'd61, 8'd62,
		8'd64, 8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71,
		8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79,
		8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87, 8'd88,
		8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95, 8'd96,
		8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103, 8'd104,
		8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111, 8'd112,
		8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120,
		8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128
	};

	localparam logic [7:0] TAB_A2U [128] = '{
		8'd1, 8'd3, 8'd5, 8'd7, 8'd9, 8'd11, 8'd13, 8'd15,
		8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23,
		8'd24, 8'd25, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31,
		8'd32, 8'd32, 8'd33, 8'd33, 8'd34, 8'd34, 8'd35, 8'd35,
		8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
		8'd44, 8'd45, 8'd46, 8'd47, 8'd48, 8'd48, 8'd49, 8'd49,
		8'd50, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55, 8'd56, 8'd57,
		8'd58, 8'd59, 8'd60, 8'd61, 8'd62, 8'd63, 8'd64, 8'd64,
		8'd65, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72,
		8'd73, 8'd74, 8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd79,
		8'd80, 8'd81, 8'd82, 8'd83, 8'd84, 8'd85, 8'd86, 8'd87,
		8'd88, 8'd89, 8'd90, 8'd91, 8'd92, 8'd93, 8'd94, 8'd95,
		8'd96, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101, 8'd102, 8'd103,
		8'd104, 8'd105, 8'd106, 8'd107, 8'd108, 8'd109, 8'd110, 8'd111,
		8'd112, 8'd113, 8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119,
		8'd120, 8'd121, 8'd122, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127
	};

	typedef struct packed {
		logic [7:0] a_code;
		logic [7:0] u_code;
	} enc_res_t;

	typedef struct packed {
		logic [15:0] a_pcm;
		logic [15:0] u_pcm;
		logic [7:0]  a2u;
		logic [7:0]  u2a;
	} xlat_res_t;

	// first segment whose end is not below mag; 8 when none
	function automatic logic [3:0] seg_find(input mag_t mag, input logic mu);
		logic [3:0] seg;
		mag_t       lim;
		seg = 4'd8;
		for (int k = 7; k >= 0; k--) begin
			lim = mu ? U_SEG_END[k] : A_SEG_END[k];
			if (mag <= lim) begin
				seg = 4'(k);
			end
		end
		return seg;
	endfunction

endpackage

// ----- rtl/core/g711_companding_codec_core.sv -----
// ----------------------------------------------------------------------------
// G.711 companding codec core
// Stateless A-law / mu-law encode, decode and transcode, one op per beat.
//
//   channel  | handshake        | payload
//   ---------+------------------+---------------------------
//   command  | start / busy     | opcode, pcm_in, code_in
//   result   | done (strobe)    | code_out, pcm_out
//
// One beat per clock; each command passes through the input register and the
// result register around the combinational encode/decode/table logic before its
// result is strobed. busy is always low.
// Reset clears the valid flags only; items in flight are dropped, none is created.
// The receiver must take every result in the cycle it is strobed; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "g711_companding_codec_core_macros.svh"

module g711_companding_codec_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         opcode,
	input  logic signed [15:0] pcm_in,
	input  logic [7:0]         code_in,
	output logic               done,
	output logic [7:0]         code_out,
	output logic signed [15:0] pcm_out
);

	logic                valid_s1;
	g711_pkg::op_t       op_s1;
	logic signed [15:0]  pcm_s1;
	logic [7:0]          code_s1;
	logic                valid_s2;
	logic [7:0]          code_s2;
	logic [15:0]         pcm_s2;
	g711_pkg::enc_res_t  enc_res;
	g711_pkg::xlat_res_t xlat_res;
	logic [7:0]          code_nxt;
	logic [15:0]         pcm_nxt;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= opcode;
		pcm_s1  <= pcm_in;
		code_s1 <= code_in;
		code_s2 <= code_nxt;
		pcm_s2  <= pcm_nxt;
	end

	g711_enc u_enc (
		.pcm (pcm_s1),
		.res (enc_res)
	);

	g711_xlat u_xlat (
		.code (code_s1),
		.res  (xlat_res)
	);

	always_comb begin
		code_nxt = 8'h00;
		pcm_nxt  = 16'h0000;
		case (op_s1)
			g711_pkg::OP_ENC_A: code_nxt = enc_res.a_code;
			g711_pkg::OP_ENC_U: code_nxt = enc_res.u_code;
			g711_pkg::OP_DEC_A: pcm_nxt  = xlat_res.a_pcm;
			g711_pkg::OP_DEC_U: pcm_nxt  = xlat_res.u_pcm;
			g711_pkg::OP_A2U:   code_nxt = xlat_res.a2u;
			g711_pkg::OP_U2A:   code_nxt = xlat_res.u2a;
			default: begin
				code_nxt = 8'h00;
				pcm_nxt  = 16'h0000;
			end
		endcase
	end

	assign done     = valid_s2;
	assign code_out = code_s2;
	assign pcm_out  = pcm_s2;

	`G711_ASSERT_NEXT(a_cmd_flows, clk, arst_n, start, valid_s1, "accepted beat lost in s1")
	`G711_ASSERT_NEXT(a_res_flows, clk, arst_n, valid_s1, done, "s1 beat not strobed out")
	`G711_ASSERT_IMPL(a_one_field, clk, arst_n, done && (pcm_out != 16'h0000), code_out == 8'h00, "both result fields nonzero")
	`G711_ASSERT_NEXT(a_enc_sign, clk, arst_n, valid_s1 && ((op_s1 == g711_pkg::OP_ENC_A) || (op_s1 == g711_pkg::OP_ENC_U)), code_out[7] == !$past(pcm_s1[15]), "encoded sign bit wrong")

endmodule

// ----- rtl/core/g711_enc.sv -----
// ----------------------------------------------------------------------------
// G.711 encoder
// Linear sample to A-law and mu-law bytes, both formed in parallel.
// ----------------------------------------------------------------------------
module g711_enc (
	input  logic signed [15:0] pcm,
	output g711_pkg::enc_res_t res
);

	logic        neg;
	logic [15:0] a_sh;
	logic [11:0] a_mag;
	logic [3:0]  a_seg;
	logic [11:0] a_shift;
	logic [3:0]  a_mant;
	logic [7:0]  a_msk;
	logic [15:0] u_sh;
	logic [15:0] u_mag_raw;
	logic [12:0] u_clip;
	logic [13:0] u_bias;
	logic [3:0]  u_seg;
	logic [13:0] u_shift;
	logic [7:0]  u_msk;

	assign neg = pcm[15];

	// A-law
	assign a_sh    = {{3{pcm[15]}}, pcm[15:3]};
	assign a_mag   = neg ? ~a_sh[11:0] : a_sh[11:0];
	assign a_seg   = g711_pkg::seg_find({2'b00, a_mag}, 1'b0);
	assign a_shift = a_mag >> a_seg[2:0];
	assign a_mant  = (a_seg < 4'd2) ? a_mag[4:1] : a_shift[3:0];
	assign a_msk   = neg ? g711_pkg::A_MSK_NEG : g711_pkg::A_MSK_POS;

	always_comb begin
		if (a_seg[3]) begin
			res.a_code = g711_pkg::CODE_MAX ^ a_msk;
		end else begin
			res.a_code = {1'b0, a_seg[2:0], a_mant} ^ a_msk;
		end
	end

	// mu-law
	assign u_sh      = {{2{pcm[15]}}, pcm[15:2]};
	assign u_mag_raw = neg ? (16'h0000 - u_sh) : u_sh;
	assign u_clip    = (u_mag_raw > {2'b00, g711_pkg::U_CLIP}) ? g711_pkg::U_CLIP[12:0]
	                                                           : u_mag_raw[12:0];
	assign u_bias    = {1'b0, u_clip} + g711_pkg::U_BIAS;
	assign u_seg     = g711_pkg::seg_find(u_bias, 1'b1);
	assign u_shift   = u_bias >> ({1'b0, u_seg[2:0]} + 4'd1);
	assign u_msk     = neg ? g711_pkg::U_MSK_NEG : g711_pkg::U_MSK_POS;

	always_comb begin
		if (u_seg[3]) begin
			res.u_code = g711_pkg::CODE_MAX ^ u_msk;
		end else begin
			res.u_code = {1'b0, u_seg[2:0], u_shift[3:0]} ^ u_msk;
		end
	end

endmodule

// ----- rtl/core/g711_xlat.sv -----
// ----------------------------------------------------------------------------
// G.711 decoder and transcoder
// Companded byte to linear sample and to the other law, all in parallel.
// ----------------------------------------------------------------------------
module g711_xlat (
	input  logic [7:0]          code,
	output g711_pkg::xlat_res_t res
);

	logic [7:0]  a_v;
	logic [2:0]  a_seg;
	logic [14:0] a_base;
	logic [14:0] a_t;
	logic [7:0]  u_v;
	logic [7:0]  u_base;
	logic [14:0] u_t;
	logic [7:0]  a2u_raw;
	logic [7:0]  u2a_raw;

	// A-law decode
	assign a_v    = code ^ g711_pkg::A_MSK_NEG;
	assign a_seg  = a_v[6:4];
	assign a_base = {7'b0, a_v[3:0], 4'b0} + ((a_seg == 3'd0) ? 15'h0008 : 15'h0108);
	assign a_t    = (a_seg > 3'd1) ? (a_base << (a_seg - 3'd1)) : a_base;
	assign res.a_pcm = a_v[7] ? {1'b0, a_t} : (16'h0000 - {1'b0, a_t});

	// mu-law decode
	assign u_v    = ~code;
	assign u_base = {1'b0, u_v[3:0], 3'b0} + 8'h84;
	assign u_t    = {7'b0, u_base} << u_v[6:4];
	assign res.u_pcm = u_v[7] ? (16'h0084 - {1'b0, u_t}) : ({1'b0, u_t} - 16'h0084);

	// transcode
	assign a2u_raw = g711_pkg::TAB_A2U[code[6:0] ^ 7'h55];
	assign u2a_raw = g711_pkg::TAB_U2A[code[6:0] ^ 7'h7F] - 8'd1;
	assign res.a2u = a2u_raw ^ (code[7] ? g711_pkg::U_MSK_POS : g711_pkg::U_MSK_NEG);
	assign res.u2a = u2a_raw ^ (code[7] ? g711_pkg::A_MSK_POS : g711_pkg::A_MSK_NEG);

endmodule
